>>> sv/mtf_pkg.sv
// Shared constants and types for the move-to-front byte list.
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

  // Size of the list and of one entry.
  localparam int SLOT_COUNT = 8;
  localparam int VALUE_BITS = 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Fixed widths of the input and result ports.
  localparam int OUT_SLOTS  = 8;
  localparam int OUT_BITS   = 8;
  localparam int OUT_IDX_W  = 3;
  localparam int IN_BITS    = 8;

  typedef logic [VALUE_BITS-1:0] slot_value_t;
  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic load;     // an item is accepted this cycle
    logic any_hit;  // the item matched at least one slot
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/mtf_cell.sv
// One list slot: stores an entry, compares it and takes its lower neighbor's entry on a shift.
`timescale 1ns / 1ps
`default_nettype none

module mtf_cell
  import mtf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cell_ctl_t   ctl,
  input  wire slot_value_t key_value,
  input  wire slot_value_t left_value,
  input  wire logic        match_above_in,
  output logic             match_here,
  output logic             match_above_out,
  output slot_value_t      slot_value
);

  slot_value_t slot_r;
  slot_value_t slot_nxt;
  logic        shift;

  assign match_here      = (slot_r == key_value);
  assign match_above_out = match_here | match_above_in;

  // A slot at or below the highest match moves up; on a miss every slot moves.
  assign shift = match_above_out | ~ctl.any_hit;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.load && shift) begin
      slot_nxt = left_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_value = slot_r;

endmodule

`default_nettype wire

>>> sv/move_to_front_byte_list_unit.sv
// Top level of the move-to-front byte list: a chain of slot cells and the result register.
//
// Usage: each item on the in_ channel carries one byte, in_book_value. The
// block compares it with all eight slots at once, moves the highest matching
// entry (or, on a miss, drops the oldest) and writes the byte to slot 0.
// One result item follows every input item on the out_ channel: the hit
// flag, the highest matching slot and the eight slots after the update.
// The result is registered: an item accepted at one edge has its result valid
// right after that edge. Throughput is one item per cycle while out_ready is high;
// the compare and the priority chain from the last cell down to cell 0 set the cycle.
// The slot cells themselves hold the shown list, so a new item is accepted
// in the cycle its predecessor's result is taken. If the receiver stalls,
// the result holds and in_ready stays low until out_ready rises.
// Synchronous reset clears every slot to zero and empties the result
// register; right after reset a zero input hits at slot 7.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_byte_list_unit
  import mtf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IN_BITS-1:0]   in_book_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_was_present,
  output logic [OUT_IDX_W-1:0]      out_found_slot,
  output logic [OUT_BITS-1:0]       out_slot0,
  output logic [OUT_BITS-1:0]       out_slot1,
  output logic [OUT_BITS-1:0]       out_slot2,
  output logic [OUT_BITS-1:0]       out_slot3,
  output logic [OUT_BITS-1:0]       out_slot4,
  output logic [OUT_BITS-1:0]       out_slot5,
  output logic [OUT_BITS-1:0]       out_slot6,
  output logic [OUT_BITS-1:0]       out_slot7
);

  slot_value_t                key_value;
  slot_value_t                slot_vals   [SLOT_COUNT];
  slot_value_t                left_vals   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]      match_vec;
  logic [SLOT_COUNT:0]        above_chain;
  cell_ctl_t                  ctl;
  logic                       accept;
  slot_idx_t                  hit_pos;
  logic [OUT_BITS-1:0]        out_bytes   [OUT_SLOTS];

  logic                       valid_r, valid_nxt;
  logic                       hit_r, hit_nxt;
  logic [OUT_IDX_W-1:0]       found_r, found_nxt;

  assign key_value   = VALUE_BITS'(in_book_value);
  assign in_ready    = ~valid_r | out_ready;
  assign accept      = in_valid & in_ready;
  assign ctl.load    = accept;
  assign ctl.any_hit = above_chain[0];
  assign above_chain[SLOT_COUNT] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign left_vals[gi] = key_value;
      end else begin : g_body
        assign left_vals[gi] = slot_vals[gi-1];
      end

      mtf_cell u_cell (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .key_value       (key_value),
        .left_value      (left_vals[gi]),
        .match_above_in  (above_chain[gi+1]),
        .match_here      (match_vec[gi]),
        .match_above_out (above_chain[gi]),
        .slot_value      (slot_vals[gi])
      );
    end
  endgenerate

  // The highest matching slot wins.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (match_vec[i]) begin
        hit_pos = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    found_nxt = found_r;
    if (accept) begin
      valid_nxt = 1'b1;
      hit_nxt   = ctl.any_hit;
      found_nxt = ctl.any_hit ? OUT_IDX_W'(hit_pos) : '0;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    found_r <= found_nxt;
  end

  // The cells only change on an accepted item, so they hold while stalled.
  always_comb begin
    for (int k = 0; k < OUT_SLOTS; k++) begin
      out_bytes[k] = '0;
      if (k < SLOT_COUNT) begin
        out_bytes[k] = OUT_BITS'(slot_vals[k]);
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_was_present = hit_r;
  assign out_found_slot  = found_r;
  assign out_slot0       = out_bytes[0];
  assign out_slot1       = out_bytes[1];
  assign out_slot2       = out_bytes[2];
  assign out_slot3       = out_bytes[3];
  assign out_slot4       = out_bytes[4];
  assign out_slot5       = out_bytes[5];
  assign out_slot6       = out_bytes[6];
  assign out_slot7       = out_bytes[7];

`ifndef SYNTHESIS
  a_head_takes_value: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_slot0 == OUT_BITS'($past(key_value))))
    else $error("slot 0 does not hold the accepted value");

  a_miss_shifts_all: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !ctl.any_hit) |=> (out_slot1 == $past(out_slot0)))
    else $error("miss did not shift slot 0 into slot 1");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_was_present) |-> (out_found_slot == '0))
    else $error("found slot set on a miss");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_stall_holds_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_slot0) && $stable(out_slot7))
    else $error("list changed while the result was stalled");
`endif

endmodule

`default_nettype wire
